FILE: hdl/bscarr_pkg.sv
// Shared constants, types and a helper for the bitmap sparse child array.
package bscarr_pkg;

    localparam int ENTRIES = 16;
    localparam int SLOT_W  = 4;
    localparam int DATA_W  = 64;
    localparam int COUNT_W = 5;

    typedef enum logic
    {
        FUNC_READ  = 1'b0,
        FUNC_WRITE = 1'b1
    } func_t;

    // controller -> datapath
    typedef struct packed
    {
        logic exec;
    } dp_cmd_t;

    function automatic logic [COUNT_W-1:0] ones_in(input logic [ENTRIES-1:0] bits);
        logic [COUNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            n = n + COUNT_W'(bits[i]);
        end
        return n;
    endfunction

endpackage

FILE: hdl/bscarr_ctrl.sv
// Handshake controller: tracks the output register and issues execute commands.
module bscarr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output bscarr_pkg::dp_cmd_t cmd
);
    import bscarr_pkg::*;

    typedef enum logic
    {
        ST_EMPTY,
        ST_FULL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign out_valid = (state_reg == ST_FULL);
    // the output word may be replaced in the same cycle it is taken
    assign in_stall  = (state_reg == ST_FULL) && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cmd.exec  = accept;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY:
            begin
                if (accept)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (!out_stall && !accept)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/bscarr_dp.sv
// Datapath: presence bitmap, packed entry registers, insert shift and output word.
module bscarr_dp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  bscarr_pkg::dp_cmd_t         cmd,
    input  logic                        func,
    input  logic [bscarr_pkg::SLOT_W-1:0]  slot,
    input  logic [bscarr_pkg::DATA_W-1:0]  write_value,
    output logic [bscarr_pkg::DATA_W-1:0]  read_value,
    output logic                        present,
    output logic [bscarr_pkg::COUNT_W-1:0] stored_count
);
    import bscarr_pkg::*;

    logic [ENTRIES-1:0]  presence_reg;
    logic [ENTRIES-1:0]  presence_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [DATA_W-1:0]   entries_reg [ENTRIES];
    logic [DATA_W-1:0]   entries_next [ENTRIES];
    logic [DATA_W-1:0]   shifted_up [ENTRIES];
    logic [DATA_W-1:0]   read_value_reg;
    logic                present_reg;
    logic [COUNT_W-1:0]  stored_count_reg;

    logic [ENTRIES-1:0]  below_mask;
    logic [SLOT_W-1:0]   pos;
    logic                was_set;
    logic                is_write;
    logic                insert;
    logic                overwrite;
    logic [DATA_W-1:0]   rd_data;

    assign is_write  = (func_t'(func) == FUNC_WRITE);
    assign was_set   = presence_reg[slot];
    assign insert    = cmd.exec && is_write && !was_set && (write_value != '0);
    assign overwrite = cmd.exec && is_write && was_set;
    assign rd_data   = (!is_write && was_set) ? entries_reg[pos] : '0;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            below_mask[i] = (SLOT_W'(i) < slot);
        end
    end

    assign pos = SLOT_W'(ones_in(presence_reg & below_mask));

    always_comb
    begin
        shifted_up[0] = entries_reg[0];
        for (int k = 1; k < ENTRIES; k++)
        begin
            shifted_up[k] = entries_reg[k-1];
        end
    end

    always_comb
    begin
        presence_next = presence_reg;
        count_next    = count_reg;
        if (insert)
        begin
            presence_next[slot] = 1'b1;
            count_next          = count_reg + COUNT_W'(1);
        end
        for (int k = 0; k < ENTRIES; k++)
        begin
            entries_next[k] = entries_reg[k];
            if ((insert || overwrite) && (SLOT_W'(k) == pos))
            begin
                entries_next[k] = write_value;
            end
            else if (insert && (SLOT_W'(k) > pos) && (COUNT_W'(k) <= count_reg))
            begin
                // open the gap: entries at and above pos move up one place
                entries_next[k] = shifted_up[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presence_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            presence_reg <= presence_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ENTRIES; k++)
        begin
            entries_reg[k] <= entries_next[k];
        end
        if (cmd.exec)
        begin
            read_value_reg   <= rd_data;
            present_reg      <= presence_next[slot];
            stored_count_reg <= count_next;
        end
    end

    assign read_value   = read_value_reg;
    assign present      = present_reg;
    assign stored_count = stored_count_reg;

endmodule

FILE: hdl/bitmap_sparse_child_array_core.sv
// Top level of the bitmap sparse child array: controller plus datapath.
//
// Input channel: in_valid/in_stall carry one word of func, slot and write_value.
// func selects a read (0) or a write (1) of one of 16 logical slots.
// Output channel: out_valid/out_stall carry one result word per input word:
// read_value (slot value on a read, zero if absent or on a write), present
// (slot bit after the operation) and stored_count (packed entries after it).
//
// An accepted word appears on the output in the next cycle. Throughput is
// one word per cycle while the receiver does not stall; the bitmap popcount,
// the packed entry select and the parallel insert shift settle in the cycle.
// The output register is the only buffer, so a new word is taken in the same
// cycle the pending result leaves.
//
// While the receiver stalls with a result pending, in_stall is raised and the
// result word holds. Reset clears the presence bitmap and the entry count;
// the packed entry registers are not cleared, since no read can reach an
// entry that was never written. No clearing pass is needed after reset.
module bitmap_sparse_child_array_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [bscarr_pkg::SLOT_W-1:0]  slot,
    input  logic [bscarr_pkg::DATA_W-1:0]  write_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bscarr_pkg::DATA_W-1:0]  read_value,
    output logic                          present,
    output logic [bscarr_pkg::COUNT_W-1:0] stored_count
);
    import bscarr_pkg::*;

    dp_cmd_t cmd;

    bscarr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    bscarr_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (func),
        .slot         (slot),
        .write_value  (write_value),
        .read_value   (read_value),
        .present      (present),
        .stored_count (stored_count)
    );

`ifndef SYNTH
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted word produced no result");

    a_nonzero_write_sets_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (func_t'(func) == FUNC_WRITE) && (write_value != '0))
        |=> present)
        else $error("nonzero write left slot absent");

    a_write_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (func_t'(func) == FUNC_WRITE)) |=> (read_value == '0))
        else $error("write result carries nonzero read_value");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (stored_count <= COUNT_W'(ENTRIES)))
        else $error("stored_count exceeds slot count");
`endif

endmodule

FILE: test/bitmap_sparse_child_array_core_test.sv
// Self-checking testbench for the bitmap sparse child array core.
module bitmap_sparse_child_array_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bscarr_pkg::*;

    localparam int RANDOM_WORDS = 1600;
    localparam int PHASE_WORDS  = 400;
    localparam int DIRECTED_OPS = 21;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed
    {
        logic [DATA_W-1:0]  value;
        logic               present;
        logic [COUNT_W-1:0] count;
    } slot_result_t;

    typedef struct packed
    {
        func_t              f;
        logic [SLOT_W-1:0]  s;
        logic [DATA_W-1:0]  v;
        logic               typed;
        slot_result_t       want;
    } access_row_t;

    localparam slot_result_t NO_RESULT = '0;
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] TOP_BIT  = {1'b1, {(DATA_W-1){1'b0}}};

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                func;
    logic [SLOT_W-1:0]   slot;
    logic [DATA_W-1:0]   write_value;
    logic                out_valid;
    logic                out_stall;
    logic [DATA_W-1:0]   read_value;
    logic                present;
    logic [COUNT_W-1:0]  stored_count;

    // shadow copy of the bitmap and packed entries
    logic [ENTRIES-1:0]  shadow_bits;
    logic [DATA_W-1:0]   shadow_entries [ENTRIES];

    slot_result_t        pending_results [$];
    slot_result_t        oldest_result;
    access_row_t         directed_ops [DIRECTED_OPS];

    int                  idle_pct;
    int                  stall_pct;
    int                  mismatches;
    int                  cycles;

    bitmap_sparse_child_array_core DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .slot         (slot),
        .write_value  (write_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_value   (read_value),
        .present      (present),
        .stored_count (stored_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Applies one access to the shadow state and returns the result word it yields.
    task automatic sparse_access(input func_t f, input logic [SLOT_W-1:0] s,
                                 input logic [DATA_W-1:0] v, output slot_result_t r);
        int  pos;
        int  used;
        bit  was_set;
        pos     = $countones(shadow_bits & ((ENTRIES'(1) << s) - ENTRIES'(1)));
        used    = $countones(shadow_bits);
        was_set = shadow_bits[s];
        r       = NO_RESULT;
        if (f == FUNC_READ)
        begin
            if (was_set)
                r.value = shadow_entries[pos];
        end
        else if (was_set)
        begin
            shadow_entries[pos] = v;
        end
        else if (v != '0)
        begin
            // open a gap at the insert position
            for (int k = used; k > pos; k--)
                shadow_entries[k] = shadow_entries[k-1];
            shadow_entries[pos] = v;
            shadow_bits[s]      = 1'b1;
        end
        r.present = shadow_bits[s];
        r.count   = COUNT_W'($countones(shadow_bits));
    endtask

    task automatic send_word(input func_t f, input logic [SLOT_W-1:0] s,
                             input logic [DATA_W-1:0] v, input logic typed,
                             input slot_result_t want);
        slot_result_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= f;
        slot        <= s;
        write_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sparse_access(f, s, v, predicted);
        pending_results.push_back(typed ? want : predicted);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("word with nothing expected", '0, read_value);
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (read_value !== oldest_result.value)
                    report_mismatch("read_value", oldest_result.value, read_value);
                if (present !== oldest_result.present)
                    report_mismatch("present", DATA_W'(oldest_result.present),
                                    DATA_W'(present));
                if (stored_count !== oldest_result.count)
                    report_mismatch("stored_count", DATA_W'(oldest_result.count),
                                    DATA_W'(stored_count));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        func_t              f;
        logic [SLOT_W-1:0]  s;
        logic [DATA_W-1:0]  v;
        int                 pick;
        int                 idle_by_phase [4];
        int                 stall_by_phase [4];

        idle_by_phase  = '{0, 49, 0, 30};
        stall_by_phase = '{0, 0, 49, 30};
        mismatches     = 0;
        cycles         = 0;
        idle_pct       = 0;
        stall_pct      = 0;
        shadow_bits    = '0;
        for (int i = 0; i < ENTRIES; i++)
            shadow_entries[i] = '0;

        // rows with typed = 1 carry their own expectation
        directed_ops = '{
            '{FUNC_READ,  4'd0,  64'd0, 1'b1, '{64'd0, 1'b0, 5'd0}},
            '{FUNC_READ,  4'd15, 64'd0, 1'b1, '{64'd0, 1'b0, 5'd0}},
            '{FUNC_WRITE, 4'd5,  64'd0, 1'b1, '{64'd0, 1'b0, 5'd0}},
            '{FUNC_WRITE, 4'd8,  ALL_ONES, 1'b1, '{64'd0, 1'b1, 5'd1}},
            '{FUNC_WRITE, 4'd3,  64'd1, 1'b0, NO_RESULT},
            '{FUNC_READ,  4'd8,  64'd0, 1'b1, '{ALL_ONES, 1'b1, 5'd2}},
            '{FUNC_READ,  4'd3,  64'd0, 1'b0, NO_RESULT},
            '{FUNC_WRITE, 4'd15, TOP_BIT, 1'b0, NO_RESULT},
            '{FUNC_WRITE, 4'd0,  64'h0123_4567_89ab_cdef, 1'b0, NO_RESULT},
            '{FUNC_READ,  4'd15, 64'd0, 1'b1, '{TOP_BIT, 1'b1, 5'd4}},
            '{FUNC_READ,  4'd8,  64'd0, 1'b0, NO_RESULT},
            '{FUNC_WRITE, 4'd8,  64'd0, 1'b0, NO_RESULT},
            '{FUNC_READ,  4'd8,  64'd0, 1'b1, '{64'd0, 1'b1, 5'd4}},
            '{FUNC_READ,  4'd5,  64'd0, 1'b1, '{64'd0, 1'b0, 5'd4}},
            '{FUNC_WRITE, 4'd10, 64'ha5a5_a5a5_a5a5_a5a5, 1'b0, NO_RESULT},
            '{FUNC_READ,  4'd0,  64'd0, 1'b0, NO_RESULT},
            '{FUNC_READ,  4'd10, 64'd0, 1'b0, NO_RESULT},
            '{FUNC_READ,  4'd15, 64'd0, 1'b0, NO_RESULT},
            '{FUNC_WRITE, 4'd3,  64'h5a5a_5a5a_5a5a_5a5a, 1'b0, NO_RESULT},
            '{FUNC_READ,  4'd3,  64'd0, 1'b0, NO_RESULT},
            '{FUNC_READ,  4'd7,  ALL_ONES, 1'b1, '{64'd0, 1'b0, 5'd5}}
        };

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        func        <= FUNC_READ;
        slot        <= '0;
        write_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_OPS; i++)
            send_word(directed_ops[i].f, directed_ops[i].s, directed_ops[i].v,
                      directed_ops[i].typed, directed_ops[i].want);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % PHASE_WORDS == 0)
            begin
                idle_pct  = idle_by_phase[n / PHASE_WORDS];
                stall_pct = stall_by_phase[n / PHASE_WORDS];
            end
            s    = SLOT_W'($urandom_range(ENTRIES - 1));
            pick = $urandom_range(7);
            case (pick)
                0:       v = '0;
                1:       v = ALL_ONES;
                2:       v = DATA_W'(1) << $urandom_range(DATA_W - 1);
                default: v = {$urandom, $urandom};
            endcase
            f = ($urandom_range(99) < 45) ? FUNC_READ : FUNC_WRITE;
            // throttle inserts so the array fills gradually over the run
            if (f == FUNC_WRITE && !shadow_bits[s] && v != '0 && $urandom_range(11) != 0)
                v = '0;
            send_word(f, s, v, 1'b0, NO_RESULT);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
